/* hdl/e2q_pkg.sv */
package e2q_pkg;

  // Datapath widths (phase angle, CORDIC vector, multiplier operands)
  localparam int ZW       = 34;        // phase angle, 2^31 = pi, with guard bits
  localparam int XW       = 34;        // CORDIC x/y in Q30, with guard bits
  localparam int MW       = 32;        // multiplier operand, Q30
  localparam int PW       = 2 * MW;    // full product
  localparam int SW       = PW + 1;    // sum of two products
  localparam int TAB_LEN  = 32;        // arctangent table depth
  localparam int PAIR_SH  = 30;        // Q60 -> Q30 after a pair product

  // CORDIC start vector: gain compensation 0.60725293500888 in Q30
  localparam logic signed [XW-1:0] GAIN = XW'(652032874);

  // atan(2^-i) in phase units (2^31 = pi)
  localparam int ATAN_TAB [TAB_LEN] = '{
    536870912, 316933406, 167458907, 85004756,
    42667331,  21354465,  10679838,  5340245,
    2670163,   1335087,   667544,    333772,
    166886,    83443,     41722,     20861,
    10430,     5215,      2608,      1304,
    652,       326,       163,       81,
    41,        20,        10,        5,
    3,         1,         1,         0
  };

  typedef logic signed [MW-1:0] op_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;

endpackage

/* hdl/euler_to_quaternion.sv */
// ZYX Euler angles to quaternion.
//
// Input channel: in_valid / in_stall with roll, pitch and yaw as signed binary
// angles (2^(ANGLE_BITS-1) counts = pi). A request is taken on a rising edge
// where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with quat_w/x/y/z in Q1.(OUT_BITS-1);
// a part that reaches +1.0 saturates to the largest code.
//
// Path from the accepting edge to out_valid: one phase register, one register
// per CORDIC stage, five multiply/add/round stages and the output register.
// Throughput: one request per cycle while in_stall is low. The three CORDIC
// pipes run side by side and the twelve-product combine is split over
// registered multiplier stages.
//
// Reset clears the valid bits of the pipeline, output and skid registers only.
// When the receiver stalls, the result waits in the output register and the
// next finished result goes into a one-entry skid register; only once that is
// full does in_stall rise and the whole pipeline hold, so nothing is dropped.
module euler_to_quaternion #(
  parameter int ANGLE_BITS    = 16,
  parameter int OUT_BITS      = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ANGLE_BITS-1:0] in_roll_angle,
  input  logic signed [ANGLE_BITS-1:0] in_pitch_angle,
  input  logic signed [ANGLE_BITS-1:0] in_yaw_angle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [OUT_BITS-1:0]   out_quat_w,
  output logic signed [OUT_BITS-1:0]   out_quat_x,
  output logic signed [OUT_BITS-1:0]   out_quat_y,
  output logic signed [OUT_BITS-1:0]   out_quat_z
);

  localparam int NS   = CORDIC_STAGES;
  localparam int LAST = NS + 5;        // index of the final datapath stage

  localparam e2q_pkg::prod_t PAIR_RND = e2q_pkg::prod_t'(1) <<< (e2q_pkg::PAIR_SH - 1);
  localparam e2q_pkg::sum_t  OUT_RND  = e2q_pkg::sum_t'(1) <<< (60 - OUT_BITS);
  localparam e2q_pkg::sum_t  SAT_HI   =
    (e2q_pkg::sum_t'(1) <<< (OUT_BITS - 1)) - e2q_pkg::sum_t'(1);
  localparam e2q_pkg::sum_t  SAT_LO   = -(e2q_pkg::sum_t'(1) <<< (OUT_BITS - 1));

  // Flow control
  logic             en;
  logic             in_acc;
  logic             fin;
  logic             out_take;
  logic [LAST:0]    vld_r;
  logic             out_v_r;
  logic             skid_v_r;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;
  assign in_acc   = in_valid && !skid_v_r;
  assign fin      = vld_r[LAST] && en;
  assign out_take = out_v_r && !out_stall;

  // Phase: sign-extend, scale to 2^31 = pi, halve with floor
  logic signed [ANGLE_BITS-1:0] ang_in  [3];
  logic signed [32:0]           ph_full [3];
  logic signed [e2q_pkg::ZW-1:0] ph     [3];

  assign ang_in[0] = in_roll_angle;
  assign ang_in[1] = in_pitch_angle;
  assign ang_in[2] = in_yaw_angle;

  // CORDIC pipes: [angle][stage]
  logic signed [e2q_pkg::XW-1:0] x_r   [3][NS+1];
  logic signed [e2q_pkg::XW-1:0] y_r   [3][NS+1];
  logic signed [e2q_pkg::ZW-1:0] z_r   [3][NS+1];
  logic signed [e2q_pkg::XW-1:0] x_nxt [3][NS];
  logic signed [e2q_pkg::XW-1:0] y_nxt [3][NS];
  logic signed [e2q_pkg::ZW-1:0] z_nxt [3][NS];

  for (genvar a = 0; a < 3; a++) begin : g_ang
    assign ph_full[a] = 33'(ang_in[a]) <<< (32 - ANGLE_BITS);
    assign ph[a]      = e2q_pkg::ZW'(ph_full[a] >>> 1);

    for (genvar i = 0; i < NS; i++) begin : g_stage
      // rotate toward zero residual angle
      assign x_nxt[a][i] = z_r[a][i][e2q_pkg::ZW-1] ?
                           x_r[a][i] + (y_r[a][i] >>> i) :
                           x_r[a][i] - (y_r[a][i] >>> i);
      assign y_nxt[a][i] = z_r[a][i][e2q_pkg::ZW-1] ?
                           y_r[a][i] - (x_r[a][i] >>> i) :
                           y_r[a][i] + (x_r[a][i] >>> i);
      assign z_nxt[a][i] = z_r[a][i][e2q_pkg::ZW-1] ?
                           z_r[a][i] + e2q_pkg::ZW'(e2q_pkg::ATAN_TAB[i]) :
                           z_r[a][i] - e2q_pkg::ZW'(e2q_pkg::ATAN_TAB[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        x_r[a][0] <= e2q_pkg::GAIN;
        y_r[a][0] <= '0;
        z_r[a][0] <= ph[a];
        for (int i = 0; i < NS; i++) begin
          x_r[a][i+1] <= x_nxt[a][i];
          y_r[a][i+1] <= y_nxt[a][i];
          z_r[a][i+1] <= z_nxt[a][i];
        end
      end
    end
  end

  // Half-angle cosines and sines, Q30
  e2q_pkg::op_t cr, sr, cp, sp, cy, sy;
  assign cr = x_r[0][NS][e2q_pkg::MW-1:0];
  assign sr = y_r[0][NS][e2q_pkg::MW-1:0];
  assign cp = x_r[1][NS][e2q_pkg::MW-1:0];
  assign sp = y_r[1][NS][e2q_pkg::MW-1:0];
  assign cy = x_r[2][NS][e2q_pkg::MW-1:0];
  assign sy = y_r[2][NS][e2q_pkg::MW-1:0];

  // Combine: pair products (roll x pitch), round to Q30, times yaw term,
  // add/subtract, round and saturate.
  // pair index: 0 cr*cp, 1 sr*sp, 2 sr*cp, 3 cr*sp
  e2q_pkg::prod_t pp_r  [4];
  e2q_pkg::prod_t pp_rnd[4];
  e2q_pkg::op_t   pq_r  [4];
  e2q_pkg::op_t   cy1_r, sy1_r, cy2_r, sy2_r;
  e2q_pkg::prod_t t_r   [8];
  e2q_pkg::sum_t  qs_r  [4];
  e2q_pkg::sum_t  qs_rnd[4];
  logic signed [OUT_BITS-1:0] q_nxt [4];
  logic signed [OUT_BITS-1:0] q_r   [4];
  logic signed [OUT_BITS-1:0] oq_r  [4];
  logic signed [OUT_BITS-1:0] sq_r  [4];

  for (genvar k = 0; k < 4; k++) begin : g_part
    assign pp_rnd[k] = (pp_r[k] + PAIR_RND) >>> e2q_pkg::PAIR_SH;
    assign qs_rnd[k] = (qs_r[k] + OUT_RND) >>> (61 - OUT_BITS);
    assign q_nxt[k]  = (qs_rnd[k] > SAT_HI) ? SAT_HI[OUT_BITS-1:0] :
                       (qs_rnd[k] < SAT_LO) ? SAT_LO[OUT_BITS-1:0] :
                       qs_rnd[k][OUT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // pair products
      pp_r[0] <= cr * cp;
      pp_r[1] <= sr * sp;
      pp_r[2] <= sr * cp;
      pp_r[3] <= cr * sp;
      cy1_r   <= cy;
      sy1_r   <= sy;
      // round pairs back to Q30
      for (int k = 0; k < 4; k++) begin
        pq_r[k] <= pp_rnd[k][e2q_pkg::MW-1:0];
      end
      cy2_r   <= cy1_r;
      sy2_r   <= sy1_r;
      // triple products, Q60
      t_r[0]  <= pq_r[0] * cy2_r;
      t_r[1]  <= pq_r[1] * sy2_r;
      t_r[2]  <= pq_r[2] * cy2_r;
      t_r[3]  <= pq_r[3] * sy2_r;
      t_r[4]  <= pq_r[3] * cy2_r;
      t_r[5]  <= pq_r[2] * sy2_r;
      t_r[6]  <= pq_r[0] * sy2_r;
      t_r[7]  <= pq_r[1] * cy2_r;
      // w, x, y, z sums
      qs_r[0] <= e2q_pkg::SW'(t_r[0]) + e2q_pkg::SW'(t_r[1]);
      qs_r[1] <= e2q_pkg::SW'(t_r[2]) - e2q_pkg::SW'(t_r[3]);
      qs_r[2] <= e2q_pkg::SW'(t_r[4]) + e2q_pkg::SW'(t_r[5]);
      qs_r[3] <= e2q_pkg::SW'(t_r[6]) - e2q_pkg::SW'(t_r[7]);
      // rounded, saturated parts
      q_r     <= q_nxt;
    end
  end

  // Valid bits, output register and skid register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[LAST-1:0], in_acc};
      end
      if (skid_v_r) begin
        if (out_take) begin
          skid_v_r <= 1'b0;
        end
      end else if (fin) begin
        if (!out_v_r || out_take) begin
          out_v_r <= 1'b1;
        end else begin
          skid_v_r <= 1'b1;
        end
      end else if (out_take) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Output and skid data
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        oq_r <= sq_r;
      end
    end else if (fin) begin
      if (!out_v_r || out_take) begin
        oq_r <= q_r;
      end else begin
        sq_r <= q_r;
      end
    end
  end

  assign out_valid  = out_v_r;
  assign out_quat_w = oq_r[0];
  assign out_quat_x = oq_r[1];
  assign out_quat_y = oq_r[2];
  assign out_quat_z = oq_r[3];

endmodule
